### rtl/dfu_request_state_machine_macros.svh
// Assertion macros for the DFU request block.
// Used by the top level; no other dependencies.
`ifndef DFU_REQUEST_STATE_MACHINE_MACROS_SVH
`define DFU_REQUEST_STATE_MACHINE_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define DFU_ASSERT_SAME(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define DFU_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

### rtl/dfu_req_pkg.sv
// Shared constants, types and helpers for the DFU request block.
// No dependencies.
package dfu_req_pkg;

    localparam int TRANSFER_SIZE = 64;
    localparam int STORE_SIZE    = 4096;

    localparam int OPCODE_W = 3;
    localparam int CODE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int KIND_W   = 3;
    localparam int BYTE_W   = 4;
    localparam int MCMD_W   = 2;
    localparam int ADDR_W   = 28;
    localparam int COUNT_W  = 13;
    localparam int ALT_W    = 2;
    localparam int CD_W     = 4;

    localparam logic [CD_W-1:0] DETACH_FRAMES = CD_W'(10);
    localparam logic [ALT_W-1:0] ALT_MAX_UPDATE = ALT_W'(2);
    localparam logic [ALT_W-1:0] ALT_STORE = ALT_W'(1);

    localparam logic [OPCODE_W-1:0] OP_CLASS   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_SET_IF  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_GET_IF  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_DN_DATA = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_FRAME   = 3'd4;

    localparam logic [CODE_W-1:0] REQ_DETACH    = 8'h00;
    localparam logic [CODE_W-1:0] REQ_DNLOAD    = 8'h01;
    localparam logic [CODE_W-1:0] REQ_UPLOAD    = 8'h02;
    localparam logic [CODE_W-1:0] REQ_GETSTATUS = 8'h03;
    localparam logic [CODE_W-1:0] REQ_CLRSTATUS = 8'h04;
    localparam logic [CODE_W-1:0] REQ_GETSTATE  = 8'h05;
    localparam logic [CODE_W-1:0] REQ_ABORT     = 8'h06;

    localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ACK   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SEND  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RECV  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STALL = 3'd4;

    localparam logic [MCMD_W-1:0] MEM_NONE  = 2'd0;
    localparam logic [MCMD_W-1:0] MEM_READ  = 2'd1;
    localparam logic [MCMD_W-1:0] MEM_WRITE = 2'd2;

    localparam logic [WORD_W-1:0] STATUS_LEN = WORD_W'(6);
    localparam logic [WORD_W-1:0] STATE_LEN  = WORD_W'(1);

    typedef enum logic [10:0] {
        ST_APP_IDLE      = 11'b000_0000_0001,
        ST_APP_DETACH    = 11'b000_0000_0010,
        ST_IDLE          = 11'b000_0000_0100,
        ST_DNLOAD_SYNC   = 11'b000_0000_1000,
        ST_DNBUSY        = 11'b000_0001_0000,
        ST_DNLOAD_IDLE   = 11'b000_0010_0000,
        ST_MANIFEST_SYNC = 11'b000_0100_0000,
        ST_MANIFEST      = 11'b000_1000_0000,
        ST_MANIFEST_WAIT = 11'b001_0000_0000,
        ST_UPLOAD_IDLE   = 11'b010_0000_0000,
        ST_ERROR         = 11'b100_0000_0000
    } dfu_state_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [CODE_W-1:0]   request_code;
        logic [WORD_W-1:0]   setup_value;
        logic [WORD_W-1:0]   setup_length;
    } dfu_req_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]  reply_kind;
        logic [WORD_W-1:0]  reply_length;
        logic [BYTE_W-1:0]  reply_byte;
        logic [MCMD_W-1:0]  memory_command;
        logic [ADDR_W-1:0]  memory_address;
        logic [COUNT_W-1:0] memory_count;
        logic               restart_to_app;
        logic               restart_to_updater;
    } dfu_req_result_t;

    typedef struct packed {
        logic valid;
        logic fire;
    } dfu_req_flow_t;

    function automatic logic [BYTE_W-1:0] state_code(input dfu_state_t st);
        logic [BYTE_W-1:0] code;
        unique case (st)
            ST_APP_IDLE:      code = 4'd0;
            ST_APP_DETACH:    code = 4'd1;
            ST_IDLE:          code = 4'd2;
            ST_DNLOAD_SYNC:   code = 4'd3;
            ST_DNBUSY:        code = 4'd4;
            ST_DNLOAD_IDLE:   code = 4'd5;
            ST_MANIFEST_SYNC: code = 4'd6;
            ST_MANIFEST:      code = 4'd7;
            ST_MANIFEST_WAIT: code = 4'd8;
            ST_UPLOAD_IDLE:   code = 4'd9;
            ST_ERROR:         code = 4'd10;
            default:          code = 4'd0;
        endcase
        return code;
    endfunction

endpackage

### rtl/dfu_req_if.sv
// Channel interfaces of the DFU request block: request, reply, configuration.
// Depends on dfu_req_pkg.
interface dfu_req_in_if;
    logic                            valid;
    logic                            ready;
    logic [dfu_req_pkg::OPCODE_W-1:0] opcode;
    logic [dfu_req_pkg::CODE_W-1:0]   request_code;
    logic [dfu_req_pkg::WORD_W-1:0]   setup_value;
    logic [dfu_req_pkg::WORD_W-1:0]   setup_length;

    modport source (output valid, opcode, request_code, setup_value, setup_length,
                    input ready);
    modport sink (input valid, opcode, request_code, setup_value, setup_length,
                  output ready);
endinterface

interface dfu_req_out_if;
    logic                            valid;
    logic                            ready;
    logic [dfu_req_pkg::KIND_W-1:0]  reply_kind;
    logic [dfu_req_pkg::WORD_W-1:0]  reply_length;
    logic [dfu_req_pkg::BYTE_W-1:0]  reply_byte;
    logic [dfu_req_pkg::MCMD_W-1:0]  memory_command;
    logic [dfu_req_pkg::ADDR_W-1:0]  memory_address;
    logic [dfu_req_pkg::COUNT_W-1:0] memory_count;
    logic                            restart_to_app;
    logic                            restart_to_updater;

    modport source (output valid, reply_kind, reply_length, reply_byte, memory_command,
                    memory_address, memory_count, restart_to_app, restart_to_updater,
                    input ready);
    modport sink (input valid, reply_kind, reply_length, reply_byte, memory_command,
                  memory_address, memory_count, restart_to_app, restart_to_updater,
                  output ready);
endinterface

interface dfu_req_cfg_if;
    logic valid;
    logic ready;
    logic update_mode;

    modport source (output valid, update_mode, input ready);
    modport sink (input valid, update_mode, output ready);
endinterface

### rtl/dfu_req_in_reg.sv
// Input register of the DFU request block: holds one request beat.
// Depends on dfu_req_pkg and dfu_req_in_if.
module dfu_req_in_reg (
    input  logic                       clk,
    input  logic                       rst_n,
    dfu_req_in_if.sink                 req,
    input  logic                       space,
    output dfu_req_pkg::dfu_req_flow_t flow,
    output dfu_req_pkg::dfu_req_item_t item
);
    import dfu_req_pkg::*;

    logic          valid_reg;
    logic          valid_next;
    dfu_req_item_t item_reg;
    logic          take;

    assign flow.valid = valid_reg;
    assign flow.fire  = valid_reg && space;
    assign req.ready  = !valid_reg || space;
    assign take       = req.valid && req.ready;
    assign valid_next = take || (valid_reg && !space);
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.opcode       <= req.opcode;
            item_reg.request_code <= req.request_code;
            item_reg.setup_value  <= req.setup_value;
            item_reg.setup_length <= req.setup_length;
        end
    end

endmodule

### rtl/dfu_req_ctrl.sv
// DFU protocol state, alternate setting, download bookkeeping and detach timer.
// Decodes one request per cycle while the reply register has space; depends on dfu_req_pkg.
module dfu_req_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dfu_req_pkg::dfu_req_flow_t   flow,
    input  dfu_req_pkg::dfu_req_item_t   item,
    input  logic                         cfg_fire,
    input  logic                         cfg_mode,
    output dfu_req_pkg::dfu_req_result_t result
);
    import dfu_req_pkg::*;

    logic               mode_reg;
    logic               mode_next;
    dfu_state_t         state_reg;
    dfu_state_t         state_next;
    logic [ALT_W-1:0]   alt_reg;
    logic [ALT_W-1:0]   alt_next;
    logic [CD_W-1:0]    cd_reg;
    logic [CD_W-1:0]    cd_next;
    logic               app_arm_reg;
    logic               app_arm_next;
    logic               upd_arm_reg;
    logic               upd_arm_next;
    logic [WORD_W-1:0]  block_reg;
    logic [WORD_W-1:0]  block_next;
    logic [COUNT_W-1:0] plen_reg;
    logic [COUNT_W-1:0] plen_next;

    logic [COUNT_W-1:0] want;
    logic [WORD_W-1:0]  mult_in;
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  room;
    logic [COUNT_W-1:0] up_cnt;
    logic               up_ok;
    logic [CODE_W-1:0]  new_alt;

    assign want    = (item.setup_length > WORD_W'(TRANSFER_SIZE)) ?
                     COUNT_W'(TRANSFER_SIZE) : item.setup_length[COUNT_W-1:0];
    assign mult_in = (item.opcode == OP_DN_DATA) ? block_reg : item.setup_value;
    assign addr    = ADDR_W'(mult_in) * ADDR_W'(TRANSFER_SIZE);
    assign room    = ADDR_W'(STORE_SIZE) - addr;
    assign up_ok   = (alt_reg == ALT_STORE) && (addr < ADDR_W'(STORE_SIZE));
    assign up_cnt  = !up_ok ? '0 :
                     (ADDR_W'(want) < room) ? want : room[COUNT_W-1:0];
    assign new_alt = item.setup_value[CODE_W-1:0];

    always_comb
    begin
        mode_next    = mode_reg;
        state_next   = state_reg;
        alt_next     = alt_reg;
        cd_next      = cd_reg;
        app_arm_next = app_arm_reg;
        upd_arm_next = upd_arm_reg;
        block_next   = block_reg;
        plen_next    = plen_reg;
        result       = '0;

        if (flow.fire)
        begin
            case (item.opcode)
                OP_CLASS:
                begin
                    if (mode_reg && item.request_code == REQ_DETACH)
                    begin
                        cd_next           = DETACH_FRAMES;
                        result.reply_kind = KIND_ACK;
                    end
                    else if (!mode_reg && item.request_code == REQ_DETACH)
                    begin
                        state_next        = ST_APP_DETACH;
                        upd_arm_next      = 1'b1;
                        cd_next           = DETACH_FRAMES;
                        result.reply_kind = KIND_ACK;
                    end
                    else if (item.request_code == REQ_GETSTATUS)
                    begin
                        result.reply_kind   = KIND_SEND;
                        result.reply_length = STATUS_LEN;
                        result.reply_byte   = state_code(state_reg);
                        case (state_reg)
                            ST_DNLOAD_SYNC:   state_next = ST_DNLOAD_IDLE;
                            ST_MANIFEST_SYNC: state_next = ST_MANIFEST;
                            ST_MANIFEST:      state_next = ST_MANIFEST_WAIT;
                            ST_MANIFEST_WAIT:
                            begin
                                cd_next      = DETACH_FRAMES;
                                app_arm_next = 1'b1;
                            end
                            default: state_next = state_reg;
                        endcase
                    end
                    else if (!mode_reg)
                    begin
                        result.reply_kind = KIND_STALL;
                    end
                    else
                    begin
                        unique case (item.request_code)
                            REQ_DNLOAD:
                            begin
                                if (item.setup_length != '0)
                                begin
                                    block_next          = item.setup_value;
                                    plen_next           = want;
                                    result.reply_kind   = KIND_RECV;
                                    result.reply_length = WORD_W'(want);
                                end
                                else
                                begin
                                    state_next        = ST_MANIFEST_SYNC;
                                    result.reply_kind = KIND_ACK;
                                end
                            end
                            REQ_UPLOAD:
                            begin
                                result.reply_kind   = KIND_SEND;
                                result.reply_length = WORD_W'(up_cnt);
                                state_next          = ST_IDLE;
                                if (up_cnt != '0)
                                begin
                                    result.memory_command = MEM_READ;
                                    result.memory_address = addr;
                                    result.memory_count   = up_cnt;
                                end
                            end
                            REQ_CLRSTATUS:
                            begin
                                state_next        = ST_IDLE;
                                result.reply_kind = KIND_ACK;
                            end
                            REQ_GETSTATE:
                            begin
                                result.reply_kind   = KIND_SEND;
                                result.reply_length = STATE_LEN;
                                result.reply_byte   = state_code(state_reg);
                            end
                            REQ_ABORT:
                            begin
                                state_next        = ST_IDLE;
                                block_next        = '0;
                                result.reply_kind = KIND_ACK;
                            end
                            default: result.reply_kind = KIND_STALL;
                        endcase
                    end
                end
                OP_SET_IF:
                begin
                    if (mode_reg)
                    begin
                        if (new_alt > CODE_W'(ALT_MAX_UPDATE))
                        begin
                            result.reply_kind = KIND_STALL;
                        end
                        else
                        begin
                            if (new_alt[ALT_W-1:0] != alt_reg)
                            begin
                                alt_next   = new_alt[ALT_W-1:0];
                                state_next = ST_IDLE;
                            end
                            result.reply_kind = KIND_ACK;
                        end
                    end
                    else if (new_alt != '0)
                    begin
                        result.reply_kind = KIND_STALL;
                    end
                    else
                    begin
                        state_next        = ST_APP_IDLE;
                        alt_next          = '0;
                        result.reply_kind = KIND_ACK;
                    end
                end
                OP_GET_IF:
                begin
                    result.reply_kind   = KIND_SEND;
                    result.reply_length = WORD_W'(item.setup_length != '0);
                    result.reply_byte   = BYTE_W'(alt_reg);
                end
                OP_DN_DATA:
                begin
                    state_next        = ST_DNLOAD_SYNC;
                    result.reply_kind = KIND_ACK;
                    if (alt_reg == ALT_STORE && plen_reg != '0)
                    begin
                        result.memory_command = MEM_WRITE;
                        result.memory_address = addr;
                        result.memory_count   = plen_reg;
                    end
                end
                OP_FRAME:
                begin
                    if (cd_reg != '0)
                    begin
                        cd_next = cd_reg - CD_W'(1);
                        if (cd_reg == CD_W'(1))
                        begin
                            result.restart_to_app     = mode_reg && app_arm_reg;
                            result.restart_to_updater = !mode_reg && upd_arm_reg &&
                                                        (state_reg == ST_APP_DETACH);
                        end
                    end
                end
                default: result.reply_kind = KIND_NONE;
            endcase
        end

        if (cfg_fire)
        begin
            mode_next  = cfg_mode;
            state_next = cfg_mode ? ST_IDLE : ST_APP_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            state_reg   <= ST_APP_IDLE;
            alt_reg     <= '0;
            cd_reg      <= '0;
            app_arm_reg <= 1'b0;
            upd_arm_reg <= 1'b0;
            block_reg   <= '0;
            plen_reg    <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            state_reg   <= state_next;
            alt_reg     <= alt_next;
            cd_reg      <= cd_next;
            app_arm_reg <= app_arm_next;
            upd_arm_reg <= upd_arm_next;
            block_reg   <= block_next;
            plen_reg    <= plen_next;
        end
    end

endmodule

### rtl/dfu_req_out_reg.sv
// Output register of the DFU request block: holds one reply beat until taken.
// Depends on dfu_req_pkg and dfu_req_out_if.
module dfu_req_out_reg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dfu_req_pkg::dfu_req_flow_t   flow,
    input  dfu_req_pkg::dfu_req_result_t result,
    output logic                         space,
    dfu_req_out_if.source                rsp
);
    import dfu_req_pkg::*;

    logic            valid_reg;
    logic            valid_next;
    dfu_req_result_t result_reg;

    assign space      = !valid_reg || rsp.ready;
    assign valid_next = flow.fire || (valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flow.fire)
        begin
            result_reg <= result;
        end
    end

    assign rsp.valid              = valid_reg;
    assign rsp.reply_kind         = result_reg.reply_kind;
    assign rsp.reply_length       = result_reg.reply_length;
    assign rsp.reply_byte         = result_reg.reply_byte;
    assign rsp.memory_command     = result_reg.memory_command;
    assign rsp.memory_address     = result_reg.memory_address;
    assign rsp.memory_count       = result_reg.memory_count;
    assign rsp.restart_to_app     = result_reg.restart_to_app;
    assign rsp.restart_to_updater = result_reg.restart_to_updater;

endmodule

### rtl/dfu_request_state_machine.sv
// Top level of the DFU request block: input register, decoder, reply register.
// Depends on dfu_req_pkg, the channel interfaces and the assertion macros.
//
//   channel | dir | beat
//   --------+-----+---------------------------------------------------------
//   req     | in  | opcode, request_code, setup_value, setup_length
//   rsp     | out | reply, memory command, restart pulses (one per request)
//   cfg     | in  | update_mode; always ready
//
// A request passes the input register and is decoded into the reply register. One
// request per cycle is sustained while rsp is ready; the decoder's single pass
// over the held state sets that. A stalled rsp holds one reply and one request;
// req.ready drops only when both are full. Reset clears valid and DFU state.
`include "dfu_request_state_machine_macros.svh"

module dfu_request_state_machine (
    input  logic          clk,
    input  logic          rst_n,
    dfu_req_in_if.sink    req,
    dfu_req_out_if.source rsp,
    dfu_req_cfg_if.sink   cfg
);
    import dfu_req_pkg::*;

    dfu_req_flow_t   flow;
    dfu_req_item_t   item;
    dfu_req_result_t result;
    logic            space;
    logic            cfg_fire;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    dfu_req_in_reg u_in (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .space (space),
        .flow  (flow),
        .item  (item)
    );

    dfu_req_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .flow     (flow),
        .item     (item),
        .cfg_fire (cfg_fire),
        .cfg_mode (cfg.update_mode),
        .result   (result)
    );

    dfu_req_out_reg u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .flow   (flow),
        .result (result),
        .space  (space),
        .rsp    (rsp)
    );

    `DFU_ASSERT_SAME(a_mem_count, clk, rst_n, rsp.valid && rsp.memory_command != MEM_NONE, rsp.memory_count != '0, "memory command with zero count")
    `DFU_ASSERT_SAME(a_one_restart, clk, rst_n, rsp.valid, !(rsp.restart_to_app && rsp.restart_to_updater), "both restart pulses set")
    `DFU_ASSERT_NEXT(a_req_held, clk, rst_n, req.valid && req.ready, flow.valid, "accepted request not held")

endmodule

### test/tb.sv
// Self-checking bench for dfu_request_state_machine: it drives DFU requests, predicts every
// reply with an in-bench model of the DFU state machine and compares field by field.
// Depends on dfu_req_pkg and the channel interfaces in rtl/dfu_req_if.sv.
module tb;
    import dfu_req_pkg::*;

    localparam logic [3:0] S_APP_IDLE      = 4'd0;
    localparam logic [3:0] S_APP_DETACH    = 4'd1;
    localparam logic [3:0] S_IDLE          = 4'd2;
    localparam logic [3:0] S_DNLOAD_SYNC   = 4'd3;
    localparam logic [3:0] S_DNLOAD_IDLE   = 4'd5;
    localparam logic [3:0] S_MANIFEST_SYNC = 4'd6;
    localparam logic [3:0] S_MANIFEST      = 4'd7;
    localparam logic [3:0] S_MANIFEST_WAIT = 4'd8;
    localparam int         HOLDOFF_CYCLES  = 80;

    logic clk = 1'b0;
    logic rst_n;

    dfu_req_in_if  req_ch();
    dfu_req_out_if rsp_ch();
    dfu_req_cfg_if cfg_ch();

    dfu_request_state_machine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    dfu_req_item_t   pending_reqs[$];
    dfu_req_result_t replies_due[$];
    dfu_req_item_t   drive_item;
    dfu_req_result_t got_reply;
    dfu_req_result_t want_reply;

    // model of the DFU state
    logic               mode_q;
    logic [3:0]         dfu_st;
    logic [ALT_W-1:0]   alt_q;
    logic [CD_W-1:0]    frames_left;
    logic               app_armed;
    logic               upd_armed;
    logic [WORD_W-1:0]  dn_block;
    logic [COUNT_W-1:0] dn_len;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int holdoff_req   = 0;
    int holdoff_seen;
    int holdoff_left;
    int queued_items  = 0;
    int mode_writes   = 0;
    int mismatches    = 0;
    int replies_seen  = 0;
    int store_reads   = 0;
    int store_writes  = 0;
    int restarts      = 0;
    int input_stalls  = 0;

    always #4 clk = ~clk;

    initial
    begin
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.opcode        = '0;
        req_ch.request_code  = '0;
        req_ch.setup_value   = '0;
        req_ch.setup_length  = '0;
        rsp_ch.ready         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.update_mode   = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d replies outstanding", replies_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int unsigned clip_xfer(input logic [WORD_W-1:0] len);
        return (len > TRANSFER_SIZE) ? TRANSFER_SIZE : len;
    endfunction

    function automatic dfu_req_result_t predict_reply(input dfu_req_item_t rq);
        dfu_req_result_t r;
        int unsigned     want;
        int unsigned     addr;
        int unsigned     cnt;
        logic [7:0]      alt8;
        r    = '0;
        alt8 = rq.setup_value[7:0];
        case (rq.opcode)
            OP_CLASS:
            begin
                if (rq.request_code == REQ_GETSTATUS)
                begin
                    r.reply_kind   = KIND_SEND;
                    r.reply_length = STATUS_LEN;
                    r.reply_byte   = dfu_st;
                    case (dfu_st)
                        S_DNLOAD_SYNC:   dfu_st = S_DNLOAD_IDLE;
                        S_MANIFEST_SYNC: dfu_st = S_MANIFEST;
                        S_MANIFEST:      dfu_st = S_MANIFEST_WAIT;
                        S_MANIFEST_WAIT:
                        begin
                            frames_left = DETACH_FRAMES;
                            app_armed   = 1'b1;
                        end
                        default: ;
                    endcase
                end
                else if (!mode_q)
                begin
                    if (rq.request_code == REQ_DETACH)
                    begin
                        dfu_st       = S_APP_DETACH;
                        upd_armed    = 1'b1;
                        frames_left  = DETACH_FRAMES;
                        r.reply_kind = KIND_ACK;
                    end
                    else
                    begin
                        r.reply_kind = KIND_STALL;
                    end
                end
                else
                begin
                    case (rq.request_code)
                        REQ_DETACH:
                        begin
                            frames_left  = DETACH_FRAMES;
                            r.reply_kind = KIND_ACK;
                        end
                        REQ_DNLOAD:
                        begin
                            if (rq.setup_length != 0)
                            begin
                                dn_block       = rq.setup_value;
                                dn_len         = COUNT_W'(clip_xfer(rq.setup_length));
                                r.reply_kind   = KIND_RECV;
                                r.reply_length = WORD_W'(dn_len);
                            end
                            else
                            begin
                                dfu_st       = S_MANIFEST_SYNC;
                                r.reply_kind = KIND_ACK;
                            end
                        end
                        REQ_UPLOAD:
                        begin
                            want = clip_xfer(rq.setup_length);
                            addr = rq.setup_value * TRANSFER_SIZE;
                            cnt  = 0;
                            if (alt_q == ALT_STORE && addr < STORE_SIZE)
                                cnt = (want < STORE_SIZE - addr) ? want : STORE_SIZE - addr;
                            if (cnt != 0)
                            begin
                                r.memory_command = MEM_READ;
                                r.memory_address = ADDR_W'(addr);
                                r.memory_count   = COUNT_W'(cnt);
                            end
                            r.reply_kind   = KIND_SEND;
                            r.reply_length = WORD_W'(cnt);
                            dfu_st         = S_IDLE;
                        end
                        REQ_CLRSTATUS:
                        begin
                            dfu_st       = S_IDLE;
                            r.reply_kind = KIND_ACK;
                        end
                        REQ_GETSTATE:
                        begin
                            r.reply_kind   = KIND_SEND;
                            r.reply_length = STATE_LEN;
                            r.reply_byte   = dfu_st;
                        end
                        REQ_ABORT:
                        begin
                            dfu_st       = S_IDLE;
                            dn_block     = '0;
                            r.reply_kind = KIND_ACK;
                        end
                        default: r.reply_kind = KIND_STALL;
                    endcase
                end
            end
            OP_SET_IF:
            begin
                if (mode_q)
                begin
                    if (alt8 > ALT_MAX_UPDATE)
                    begin
                        r.reply_kind = KIND_STALL;
                    end
                    else
                    begin
                        if (alt8 != alt_q)
                        begin
                            alt_q  = ALT_W'(alt8);
                            dfu_st = S_IDLE;
                        end
                        r.reply_kind = KIND_ACK;
                    end
                end
                else if (alt8 != 0)
                begin
                    r.reply_kind = KIND_STALL;
                end
                else
                begin
                    dfu_st       = S_APP_IDLE;
                    alt_q        = '0;
                    r.reply_kind = KIND_ACK;
                end
            end
            OP_GET_IF:
            begin
                r.reply_kind   = KIND_SEND;
                r.reply_length = WORD_W'(rq.setup_length != 0);
                r.reply_byte   = BYTE_W'(alt_q);
            end
            OP_DN_DATA:
            begin
                dfu_st = S_DNLOAD_SYNC;
                if (alt_q == ALT_STORE && dn_len != 0)
                begin
                    r.memory_command = MEM_WRITE;
                    r.memory_address = ADDR_W'(dn_block * TRANSFER_SIZE);
                    r.memory_count   = dn_len;
                end
                r.reply_kind = KIND_ACK;
            end
            OP_FRAME:
            begin
                if (frames_left != 0)
                begin
                    frames_left = frames_left - 1'b1;
                    if (frames_left == 0)
                    begin
                        if (mode_q)
                            r.restart_to_app = app_armed;
                        else if (dfu_st == S_APP_DETACH && upd_armed)
                            r.restart_to_updater = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic flag_reply(input string why, input dfu_req_result_t want,
                              input dfu_req_result_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%s reply #%0d: expected kind=%0d len=%0d byte=%0d mem=%0d addr=%h cnt=%0d",
                     why, replies_seen, want.reply_kind, want.reply_length, want.reply_byte,
                     want.memory_command, want.memory_address, want.memory_count);
            $display("    app=%b upd=%b; got kind=%0d len=%0d byte=%0d mem=%0d addr=%h cnt=%0d app=%b upd=%b",
                     want.restart_to_app, want.restart_to_updater, got.reply_kind,
                     got.reply_length, got.reply_byte, got.memory_command, got.memory_address,
                     got.memory_count, got.restart_to_app, got.restart_to_updater);
        end
    endtask

    // check replies, then track config writes and accepted requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q      = 1'b0;
            dfu_st      = S_APP_IDLE;
            alt_q       = '0;
            frames_left = '0;
            app_armed   = 1'b0;
            upd_armed   = 1'b0;
            dn_block    = '0;
            dn_len      = '0;
            replies_due.delete();
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got_reply = {rsp_ch.reply_kind, rsp_ch.reply_length, rsp_ch.reply_byte,
                             rsp_ch.memory_command, rsp_ch.memory_address, rsp_ch.memory_count,
                             rsp_ch.restart_to_app, rsp_ch.restart_to_updater};
                replies_seen++;
                store_reads  += (got_reply.memory_command == MEM_READ);
                store_writes += (got_reply.memory_command == MEM_WRITE);
                restarts     += got_reply.restart_to_app + got_reply.restart_to_updater;
                if (replies_due.size() == 0)
                begin
                    flag_reply("unexpected", '0, got_reply);
                end
                else
                begin
                    want_reply = replies_due.pop_front();
                    if (got_reply.reply_kind         !== want_reply.reply_kind   ||
                        got_reply.reply_length       !== want_reply.reply_length ||
                        got_reply.reply_byte         !== want_reply.reply_byte   ||
                        got_reply.memory_command     !== want_reply.memory_command ||
                        got_reply.memory_address     !== want_reply.memory_address ||
                        got_reply.memory_count       !== want_reply.memory_count ||
                        got_reply.restart_to_app     !== want_reply.restart_to_app ||
                        got_reply.restart_to_updater !== want_reply.restart_to_updater)
                        flag_reply("mismatched", want_reply, got_reply);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                mode_q = cfg_ch.update_mode;
                dfu_st = cfg_ch.update_mode ? S_IDLE : S_APP_IDLE;
                mode_writes++;
            end
            if (req_ch.valid && !req_ch.ready)
                input_stalls++;
            if (req_ch.valid && req_ch.ready)
                replies_due.push_back(predict_reply({req_ch.opcode, req_ch.request_code,
                                                     req_ch.setup_value, req_ch.setup_length}));
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                drive_item = pending_reqs.pop_front();
                req_ch.valid        <= 1'b1;
                req_ch.opcode       <= drive_item.opcode;
                req_ch.request_code <= drive_item.request_code;
                req_ch.setup_value  <= drive_item.setup_value;
                req_ch.setup_length <= drive_item.setup_length;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_seen <= 0;
            holdoff_left <= 0;
        end
        else if (holdoff_seen != holdoff_req)
        begin
            holdoff_seen <= holdoff_req;
            holdoff_left <= HOLDOFF_CYCLES;
        end
        else if (holdoff_left != 0)
        begin
            holdoff_left <= holdoff_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= (holdoff_left == 0) && ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic queue_req(input logic [OPCODE_W-1:0] op, input logic [CODE_W-1:0] code,
                             input logic [WORD_W-1:0] value, input logic [WORD_W-1:0] len);
        pending_reqs.push_back({op, code, value, len});
        if (op <= OP_FRAME)
            queued_items++;
    endtask

    function automatic logic [WORD_W-1:0] pick_len();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return WORD_W'($urandom_range(65, 65535));
            2:       return '1;
            default: return WORD_W'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_block();
        case ($urandom_range(0, 4))
            0:       return WORD_W'($urandom_range(60, 70));
            1:       return WORD_W'($urandom);
            default: return WORD_W'($urandom_range(0, 63));
        endcase
    endfunction

    task automatic queue_noise();
        queue_req(OPCODE_W'($urandom_range(0, 7)),
                  $urandom_range(0, 1) ? CODE_W'($urandom_range(0, 7)) : CODE_W'($urandom),
                  WORD_W'($urandom), WORD_W'($urandom));
    endtask

    task automatic queue_ticks(input int n);
        repeat (n) queue_req(OP_FRAME, CODE_W'($urandom), WORD_W'($urandom), WORD_W'($urandom));
    endtask

    task automatic queue_iface();
        if ($urandom_range(0, 1))
            queue_req(OP_SET_IF, CODE_W'($urandom),
                      $urandom_range(0, 3) ? WORD_W'($urandom_range(0, 3)) : WORD_W'($urandom),
                      WORD_W'($urandom));
        else
            queue_req(OP_GET_IF, CODE_W'($urandom), WORD_W'($urandom),
                      WORD_W'($urandom_range(0, 2)));
    endtask

    // select an alternate setting, download blocks, manifest, then count down to the app reboot
    task automatic update_session();
        logic [7:0] alt;
        int         blocks;
        alt = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 2)) : 8'(ALT_STORE);
        queue_req(OP_SET_IF, CODE_W'($urandom), {8'($urandom), alt}, WORD_W'($urandom));
        blocks = $urandom_range(1, 4);
        repeat (blocks)
        begin
            queue_req(OP_CLASS, REQ_DNLOAD, pick_block(), pick_len());
            if ($urandom_range(0, 9) != 0)
                queue_req(OP_DN_DATA, CODE_W'($urandom), WORD_W'($urandom), WORD_W'($urandom));
            if ($urandom_range(0, 4) != 0)
                queue_req(OP_CLASS, REQ_GETSTATUS, WORD_W'($urandom), WORD_W'($urandom));
        end
        if ($urandom_range(0, 5) == 0)
            queue_req(OP_CLASS, REQ_ABORT, WORD_W'($urandom), WORD_W'($urandom));
        queue_req(OP_CLASS, REQ_DNLOAD, WORD_W'($urandom), '0);
        repeat ($urandom_range(2, 4))
            queue_req(OP_CLASS, REQ_GETSTATUS, WORD_W'($urandom), WORD_W'($urandom));
        queue_ticks($urandom_range(8, 12));
    endtask

    task automatic upload_burst();
        repeat ($urandom_range(1, 5))
            queue_req(OP_CLASS, REQ_UPLOAD, pick_block(), pick_len());
        if ($urandom_range(0, 1))
            queue_req(OP_CLASS, REQ_GETSTATE, WORD_W'($urandom), WORD_W'($urandom));
    endtask

    // detach, then count down to the updater reboot unless reset by set interface
    task automatic runtime_session();
        queue_req(OP_CLASS, REQ_GETSTATUS, WORD_W'($urandom), WORD_W'($urandom));
        queue_req(OP_CLASS, REQ_DETACH, WORD_W'($urandom), WORD_W'($urandom));
        if ($urandom_range(0, 1))
            queue_req(OP_CLASS, REQ_GETSTATUS, WORD_W'($urandom), WORD_W'($urandom));
        if ($urandom_range(0, 4) == 0)
            queue_req(OP_SET_IF, CODE_W'($urandom), {8'($urandom), 8'h00}, WORD_W'($urandom));
        queue_ticks($urandom_range(8, 12));
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_ch.valid || replies_due.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_mode(input logic mode);
        @(posedge clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.update_mode <= mode;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(input logic mode, input int idle, input int stall, input int n,
                             input bit long_hold);
        int start;
        write_mode(mode);
        send_idle_pct = idle;
        stall_pct     = stall;
        start         = queued_items;
        if (long_hold)
            holdoff_req++;
        while (queued_items - start < n)
        begin
            if (mode)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: update_session();
                    4, 5:       upload_burst();
                    6:          queue_req(OP_CLASS, CODE_W'($urandom_range(0, 7)),
                                          pick_block(), pick_len());
                    7:          queue_iface();
                    8:          queue_noise();
                    default:    queue_ticks($urandom_range(1, 3));
                endcase
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: runtime_session();
                    4, 5:       queue_req(OP_CLASS, CODE_W'($urandom_range(0, 7)),
                                          WORD_W'($urandom), WORD_W'($urandom));
                    6:          queue_iface();
                    default:    queue_noise();
                endcase
            end
        end
        wait_drained();
    endtask

    initial
    begin
        wait (rst_n === 1'b1);
        @(negedge clk);

        write_mode(1'b0);
        queue_req(OP_CLASS, REQ_GETSTATUS, '0, '0);
        queue_req(OP_CLASS, REQ_DNLOAD, '1, '1);
        queue_req(OP_CLASS, 8'hFF, '0, '0);
        queue_req(OP_SET_IF, '0, 16'h0100, '0);
        queue_req(OP_SET_IF, '1, 16'h00FF, '1);
        queue_req(OP_GET_IF, '0, '0, '0);
        queue_req(3'b111, '1, '1, '1);
        queue_req(OP_FRAME, '0, '0, '0);
        wait_drained();

        write_mode(1'b1);
        queue_req(OP_SET_IF, '0, 16'd3, '0);
        queue_req(OP_SET_IF, '0, 16'd0, '0);
        queue_req(OP_SET_IF, '0, 16'd1, '0);
        queue_req(OP_CLASS, REQ_DNLOAD, '1, '1);
        queue_req(OP_DN_DATA, '0, '0, '0);
        queue_req(OP_CLASS, REQ_GETSTATUS, '0, '0);
        queue_req(OP_CLASS, REQ_DNLOAD, '0, '0);
        repeat (3) queue_req(OP_CLASS, REQ_GETSTATUS, '0, '0);
        queue_req(OP_CLASS, REQ_GETSTATE, '0, '0);
        queue_req(OP_CLASS, REQ_UPLOAD, 16'd63, '1);
        queue_req(OP_CLASS, REQ_UPLOAD, 16'd64, 16'd10);
        queue_req(OP_CLASS, REQ_UPLOAD, '0, '0);
        queue_req(OP_CLASS, REQ_ABORT, '1, '1);
        queue_req(OP_CLASS, REQ_CLRSTATUS, '0, '0);
        queue_req(OP_CLASS, REQ_DETACH, '0, '0);
        queue_req(OP_CLASS, 8'd7, '0, '0);
        wait_drained();

        run_phase(1'b1, 0, 0, 130, 1'b0);
        run_phase(1'b0, 66, 0, 100, 1'b0);
        run_phase(1'b1, 0, 66, 130, 1'b0);
        run_phase(1'b1, 30, 30, 130, 1'b0);
        run_phase(1'b1, 0, 0, 60, 1'b1);
        run_phase(1'b0, 30, 30, 100, 1'b0);

        $display("Covered %0d requests across %0d mode writes in runtime and updater mode,",
                 queued_items, mode_writes);
        $display("with %0d replies, %0d store reads, %0d writes, %0d restarts, %0d held-off cycles.",
                 replies_seen, store_reads, store_writes, restarts, input_stalls);
        if (replies_due.size() != 0)
            $display("%0d expected replies never arrived", replies_due.size());
        if (mismatches == 0 && replies_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/dfu_req_pkg.sv
rtl/dfu_req_if.sv
rtl/dfu_req_in_reg.sv
rtl/dfu_req_ctrl.sv
rtl/dfu_req_out_reg.sv
rtl/dfu_request_state_machine.sv
test/tb.sv
